// File: src/fagt_pkg.sv
// ----------------------------------------------------------------------------
// fagt_pkg: shared types and constants of the frame alignment core
// Opcodes, controller states, command and status bundles and the fixed
// arithmetic constants of the rotation datapath.
// ----------------------------------------------------------------------------
package fagt_pkg;

  localparam int ROT_BITS = 28;
  localparam int VW       = 35;   // working coordinate width, signed
  localparam int MAGW     = 34;   // magnitude of a working coordinate
  localparam int QW       = 29;   // tq, u, inv, oth and rotation factors
  localparam int AW       = 64;   // arithmetic unit operand width
  localparam int BW       = 35;   // divisor / multiplicand width
  localparam int RMW      = 36;   // partial remainder width
  localparam int ACCW     = 66;   // rotation accumulator width

  localparam logic signed [VW-1:0] MAG_LIM = 35'sd17179869183;

  typedef enum logic [3:0] {
    OP_PREP,
    OP_DIVT,
    OP_SQRT,
    OP_DIVI,
    OP_OTH,
    OP_MULR,
    OP_MA,
    OP_MB,
    OP_MC,
    OP_MD,
    OP_ROTWB,
    OP_SCALE
  } op_t;

  typedef enum logic [1:0] {
    AM_DIV,
    AM_SQRT,
    AM_MUL
  } amode_t;

  typedef enum logic [3:0] {
    S_LOAD  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_WAIT  = 4'b0100,
    S_PUSH  = 4'b1000
  } state_t;

  typedef struct packed {
    logic start;
    op_t  op;
    logic load;
    logic push;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic out_busy;
  } sts_t;

  function automatic logic [MAGW-1:0] mag_of(input logic signed [VW-1:0] v);
    logic signed [VW-1:0] n;
    n = -v;
    return v[VW-1] ? n[MAGW-1:0] : v[MAGW-1:0];
  endfunction

endpackage

// File: src/frame_align_givens_transform_core.sv
// ----------------------------------------------------------------------------
// frame_align_givens_transform_core: Givens rotation frame alignment
// The one shared serial unit (64 divide steps, 32 root steps, 35 multiply
// steps) serves every rotation and every emitted coordinate; a new vector is
// taken only after the last coordinate of the previous one has been pushed.
// Synchronous active-low reset clears the controller, the load count and
// the output valid, and sets dims to 2.
// ----------------------------------------------------------------------------
module frame_align_givens_transform_core import fagt_pkg::*; #(
  parameter int MAX_DIMS  = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // origin_value, target_value, point_value
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // frame_coord
  output logic        out_tlast,  // coord_last
  output logic [0:0]  out_tuser,  // degenerate
  // dims register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data
);

  localparam int IDXW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

  cmd_t            cmd;
  sts_t            sts;
  logic [IDXW-1:0] idx;
  logic            degen;

  // Sequencer: counts transfers into the working vectors, then walks the
  // planes (0,i) and finally the per-coordinate divide.
  fagt_ctrl #(.MAX_DIMS(MAX_DIMS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .sts       (sts),
    .cmd       (cmd),
    .idx       (idx)
  );

  // Datapath: translate on load, rotate in place, scale into the output
  // register, which holds a result while the next one is computed.
  fagt_dp #(.MAX_DIMS(MAX_DIMS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .idx          (idx),
    .origin_value (in_tdata[31:0]),
    .target_value (in_tdata[63:32]),
    .point_value  (in_tdata[95:64]),
    .sts          (sts),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .frame_coord  (out_tdata),
    .coord_last   (out_tlast),
    .degenerate   (degen)
  );

  assign out_tuser = degen;

  // a degenerate divisor forces the coordinate to zero
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == 32'd0)
    else $error("degenerate coordinate not zero");

  // the datapath only reports completion while a command is outstanding
  a_done_not_loading: assert property (@(posedge clk) disable iff (!rst_n)
    sts.done |-> !in_tready)
    else $error("completion while loading");

  // a fresh result always follows a push from the sequencer
  a_push_before_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(cmd.push))
    else $error("result appeared without push");

endmodule

// File: src/fagt_arith.sv
// ----------------------------------------------------------------------------
// fagt_arith: shared serial arithmetic unit
// Restoring divide (one quotient bit a cycle), square root (one root bit a
// cycle) and shift-add multiply (one multiplier bit a cycle).
// ----------------------------------------------------------------------------
module fagt_arith import fagt_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  amode_t          mode,
  input  logic [AW-1:0]   a,
  input  logic [BW-1:0]   b,
  output logic            done,
  output logic [AW-1:0]   res
);

  localparam logic [6:0] DIV_STEPS  = 7'd64;
  localparam logic [6:0] SQRT_STEPS = 7'd32;
  localparam logic [6:0] MUL_STEPS  = 7'd35;

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [6:0]      cnt_r, cnt_nxt;
  amode_t          mode_r, mode_nxt;
  logic [AW-1:0]   acc_r, acc_nxt;
  logic [RMW-1:0]  rem_r, rem_nxt;
  logic [BW-1:0]   opb_r, opb_nxt;
  logic [AW-1:0]   res_r, res_nxt;

  logic [RMW-1:0]  trial;
  logic [RMW-1:0]  cmpv;
  logic            ge;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    opb_nxt  = opb_r;
    res_nxt  = res_r;
    trial    = '0;
    cmpv     = '0;
    ge       = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      mode_nxt = mode;
      rem_nxt  = '0;
      res_nxt  = '0;
      opb_nxt  = b;
      case (mode)
        AM_DIV: begin
          acc_nxt = a;
          cnt_nxt = DIV_STEPS;
        end
        AM_SQRT: begin
          acc_nxt = a;
          cnt_nxt = SQRT_STEPS;
        end
        default: begin
          acc_nxt = {a[BW-1:0], {(AW-BW){1'b0}}};
          cnt_nxt = MUL_STEPS;
        end
      endcase
    end else if (busy_r) begin
      case (mode_r)
        AM_DIV: begin
          trial   = {rem_r[RMW-2:0], acc_r[AW-1]};
          cmpv    = {1'b0, opb_r};
          ge      = (trial >= cmpv);
          rem_nxt = ge ? (trial - cmpv) : trial;
          res_nxt = {res_r[AW-2:0], ge};
          acc_nxt = {acc_r[AW-2:0], 1'b0};
        end
        AM_SQRT: begin
          trial   = {rem_r[RMW-3:0], acc_r[AW-1:AW-2]};
          cmpv    = {2'b00, res_r[31:0], 2'b01};
          ge      = (trial >= cmpv);
          rem_nxt = ge ? (trial - cmpv) : trial;
          res_nxt = {res_r[AW-2:0], ge};
          acc_nxt = {acc_r[AW-3:0], 2'b00};
        end
        default: begin
          res_nxt = {res_r[AW-2:0], 1'b0} +
                    (acc_r[AW-1] ? {{(AW-BW){1'b0}}, opb_r} : {AW{1'b0}});
          acc_nxt = {acc_r[AW-2:0], 1'b0};
        end
      endcase
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      mode_r <= AM_DIV;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      mode_r <= mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    opb_r <= opb_nxt;
    res_r <= res_nxt;
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

// File: src/fagt_dp.sv
// ----------------------------------------------------------------------------
// fagt_dp: rotation and scaling datapath
// Working vectors, rotation factors, accumulators and the output register,
// driven by controller commands around the shared arithmetic unit.
// ----------------------------------------------------------------------------
module fagt_dp import fagt_pkg::*; #(
  parameter int MAX_DIMS  = 8,
  parameter int FRAC_BITS = 16,
  localparam int IDXW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  input  logic [IDXW-1:0]    idx,
  input  logic signed [31:0] origin_value,
  input  logic signed [31:0] target_value,
  input  logic signed [31:0] point_value,
  output sts_t               sts,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        frame_coord,
  output logic               coord_last,
  output logic               degenerate
);

  logic signed [VW-1:0] t_r [MAX_DIMS];
  logic signed [VW-1:0] p_r [MAX_DIMS];

  logic [MAGW-1:0]       big_r, small_r;
  logic                  swap_r, negx_r, negy_r;
  logic [QW-1:0]         tq_r, u_r, inv_r, oth_r;
  logic signed [ACCW-1:0] acc0_r, acc1_r;
  logic [31:0]           q_r;
  logic                  fast_done_r;
  logic                  out_valid_r;
  logic [31:0]           out_data_r;
  logic                  out_last_r, out_degen_r;

  logic signed [VW-1:0]  x, y, p0, pi;
  logic [MAGW-1:0]       ax, ay, ap0, api;
  logic [QW-1:0]         cmag, smag;
  logic                  t0_zero;
  logic                  use_arith;
  amode_t                amode;
  logic [AW-1:0]         aa;
  logic [BW-1:0]         ab;
  logic                  a_done;
  logic [AW-1:0]         a_res;
  logic [2*QW-1:0]       sq_prod, oth_prod;
  logic signed [ACCW-1:0] term;
  logic                  term_neg;
  logic [35:0]           r_full;

  function automatic logic signed [VW-1:0] round_clamp(input logic signed [ACCW-1:0] v);
    logic signed [ACCW-1:0] s;
    s = (v + (ACCW'(1) <<< (ROT_BITS - 1))) >>> ROT_BITS;
    if (s > ACCW'(MAG_LIM)) return MAG_LIM;
    if (s < -ACCW'(MAG_LIM)) return -MAG_LIM;
    return s[VW-1:0];
  endfunction

  function automatic logic [31:0] sat32(input logic [AW-1:0] m, input logic neg);
    logic [AW-1:0] n;
    n = -m;
    if (neg) return (m > AW'(64'h80000000)) ? 32'h80000000 : n[31:0];
    return (m > AW'(64'h7FFFFFFF)) ? 32'h7FFFFFFF : m[31:0];
  endfunction

  assign x   = t_r[0];
  assign y   = t_r[idx];
  assign p0  = p_r[0];
  assign pi  = p_r[idx];
  assign ax  = mag_of(x);
  assign ay  = mag_of(y);
  assign ap0 = mag_of(p0);
  assign api = mag_of(pi);
  assign cmag = swap_r ? oth_r : inv_r;
  assign smag = swap_r ? inv_r : oth_r;
  assign t0_zero = (x == '0);
  assign sq_prod  = tq_r * tq_r;
  assign oth_prod = tq_r * inv_r;
  assign r_full   = a_res[AW-1:ROT_BITS];

  // operand selection for the shared unit
  always_comb begin
    use_arith = 1'b1;
    amode     = AM_MUL;
    aa        = '0;
    ab        = '0;
    case (cmd.op)
      OP_DIVT: begin
        use_arith = (big_r != '0);
        amode     = AM_DIV;
        aa        = AW'({small_r, {ROT_BITS{1'b0}}});
        ab        = BW'(big_r);
      end
      OP_SQRT: begin
        amode = AM_SQRT;
        aa    = (AW'(1) << (2 * ROT_BITS)) + AW'(sq_prod);
      end
      OP_DIVI: begin
        amode = AM_DIV;
        aa    = AW'(1) << (2 * ROT_BITS);
        ab    = BW'(u_r);
      end
      OP_MULR: begin
        aa = AW'(u_r);
        ab = BW'(big_r);
      end
      OP_MA: begin
        aa = AW'(cmag);
        ab = BW'(ap0);
      end
      OP_MB: begin
        aa = AW'(smag);
        ab = BW'(api);
      end
      OP_MC: begin
        aa = AW'(smag);
        ab = BW'(ap0);
      end
      OP_MD: begin
        aa = AW'(cmag);
        ab = BW'(api);
      end
      OP_SCALE: begin
        use_arith = !t0_zero;
        amode     = AM_DIV;
        aa        = AW'(mag_of(pi)) << FRAC_BITS;
        ab        = BW'(ax);
      end
      default: use_arith = 1'b0;
    endcase
  end

  // sign of the product term just finished
  always_comb begin
    case (cmd.op)
      OP_MA:   term_neg = p0[VW-1] ^ negx_r;
      OP_MB:   term_neg = pi[VW-1] ^ !negy_r;
      OP_MC:   term_neg = p0[VW-1] ^ !negy_r;
      default: term_neg = pi[VW-1] ^ negx_r;
    endcase
    term = term_neg ? -$signed({2'b00, a_res}) : $signed({2'b00, a_res});
  end

  fagt_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.start && use_arith),
    .mode  (amode),
    .a     (aa),
    .b     (ab),
    .done  (a_done),
    .res   (a_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fast_done_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fast_done_r <= cmd.start && !use_arith;
      if (cmd.push) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      t_r[idx] <= VW'(target_value) - VW'(origin_value);
      p_r[idx] <= VW'(point_value) - VW'(origin_value);
    end
    if (cmd.start) begin
      case (cmd.op)
        OP_PREP: begin
          swap_r  <= (ay > ax);
          big_r   <= (ay > ax) ? ay : ax;
          small_r <= (ay > ax) ? ax : ay;
          negx_r  <= x[VW-1];
          negy_r  <= y[VW-1];
        end
        OP_DIVT:  if (!use_arith) tq_r <= '0;
        OP_OTH:   oth_r <= oth_prod[ROT_BITS+QW-1:ROT_BITS];
        OP_ROTWB: begin
          p_r[0]   <= round_clamp(acc0_r);
          p_r[idx] <= round_clamp(acc1_r);
        end
        OP_SCALE: if (!use_arith) q_r <= '0;
        default: ;
      endcase
    end
    if (a_done) begin
      case (cmd.op)
        OP_DIVT: tq_r <= a_res[QW-1:0];
        OP_SQRT: u_r  <= a_res[QW-1:0];
        OP_DIVI: inv_r <= a_res[QW-1:0];
        OP_MULR: begin
          t_r[0]   <= (r_full > 36'(MAG_LIM)) ? MAG_LIM : VW'(r_full);
          t_r[idx] <= '0;
        end
        OP_MA:   acc0_r <= term;
        OP_MB:   acc0_r <= acc0_r - term;
        OP_MC:   acc1_r <= term;
        OP_MD:   acc1_r <= acc1_r + term;
        OP_SCALE: q_r <= sat32(a_res, pi[VW-1] ^ x[VW-1]);
        default: ;
      endcase
    end
    if (cmd.push) begin
      out_data_r  <= q_r;
      out_last_r  <= cmd.last;
      out_degen_r <= t0_zero;
    end
  end

  assign sts.done     = fast_done_r | a_done;
  assign sts.out_busy = out_valid_r && !out_ready;
  assign out_valid    = out_valid_r;
  assign frame_coord  = out_data_r;
  assign coord_last   = out_last_r;
  assign degenerate   = out_degen_r;

endmodule

// File: src/fagt_ctrl.sv
// ----------------------------------------------------------------------------
// fagt_ctrl: sequencer of the frame alignment core
// Counts loaded items, holds the dims register and steps the datapath
// through the rotations and the final scaling.
// ----------------------------------------------------------------------------
module fagt_ctrl import fagt_pkg::*; #(
  parameter int MAX_DIMS = 8,
  localparam int IDXW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1,
  localparam int CNTW = $clog2(MAX_DIMS + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [3:0]      cfg_data,
  input  sts_t            sts,
  output cmd_t            cmd,
  output logic [IDXW-1:0] idx
);

  state_t          state_r, state_nxt;
  op_t             op_r, op_nxt;
  logic [CNTW-1:0] lc_r, lc_nxt;
  logic [CNTW-1:0] d_r, d_nxt;
  logic [CNTW-1:0] i_r, i_nxt;
  logic [CNTW-1:0] k_r, k_nxt;
  logic [3:0]      dims_r;
  logic [CNTW-1:0] eff;

  always_comb begin
    if (dims_r == 4'd0)                eff = CNTW'(1);
    else if (int'(dims_r) > MAX_DIMS)  eff = CNTW'(MAX_DIMS);
    else                               eff = CNTW'(dims_r);
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    lc_nxt    = lc_r;
    d_nxt     = d_r;
    i_nxt     = i_r;
    k_nxt     = k_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.op    = op_r;
    cmd.last  = ((k_r + CNTW'(1)) == d_r);
    unique case (state_r)
      S_LOAD: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        if (in_valid) begin
          if ((lc_r + CNTW'(1)) >= eff) begin
            lc_nxt    = '0;
            d_nxt     = eff;
            i_nxt     = CNTW'(1);
            k_nxt     = '0;
            op_nxt    = (eff > CNTW'(1)) ? OP_PREP : OP_SCALE;
            state_nxt = S_ISSUE;
          end else begin
            lc_nxt = lc_r + CNTW'(1);
          end
        end
      end
      S_ISSUE: begin
        cmd.start = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (sts.done) begin
          state_nxt = S_ISSUE;
          case (op_r)
            OP_PREP:  op_nxt = OP_DIVT;
            OP_DIVT:  op_nxt = OP_SQRT;
            OP_SQRT:  op_nxt = OP_DIVI;
            OP_DIVI:  op_nxt = OP_OTH;
            OP_OTH:   op_nxt = OP_MULR;
            OP_MULR:  op_nxt = OP_MA;
            OP_MA:    op_nxt = OP_MB;
            OP_MB:    op_nxt = OP_MC;
            OP_MC:    op_nxt = OP_MD;
            OP_MD:    op_nxt = OP_ROTWB;
            OP_ROTWB: begin
              if ((i_r + CNTW'(1)) < d_r) begin
                i_nxt  = i_r + CNTW'(1);
                op_nxt = OP_PREP;
              end else begin
                op_nxt = OP_SCALE;
              end
            end
            default:  state_nxt = S_PUSH;
          endcase
        end
      end
      S_PUSH: begin
        if (!sts.out_busy) begin
          cmd.push = 1'b1;
          if ((k_r + CNTW'(1)) < d_r) begin
            k_nxt     = k_r + CNTW'(1);
            op_nxt    = OP_SCALE;
            state_nxt = S_ISSUE;
          end else begin
            state_nxt = S_LOAD;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_comb begin
    if (state_r == S_LOAD)     idx = lc_r[IDXW-1:0];
    else if (op_r == OP_SCALE) idx = k_r[IDXW-1:0];
    else                       idx = i_r[IDXW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      op_r    <= OP_PREP;
      lc_r    <= '0;
      d_r     <= CNTW'(1);
      i_r     <= '0;
      k_r     <= '0;
      dims_r  <= 4'd2;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      lc_r    <= lc_nxt;
      d_r     <= d_nxt;
      i_r     <= i_nxt;
      k_r     <= k_nxt;
      if (cfg_valid) dims_r <= cfg_data;
    end
  end

  assign cfg_ready = 1'b1;

endmodule
